// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// shared characters, reply codes and the line summary type of the decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slcd_pkg;

    // line framing and argument characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // ping keyword
    localparam logic [7:0] CHAR_P_LOW = 8'h70;
    localparam logic [7:0] CHAR_I_LOW = 8'h69;
    localparam logic [7:0] CHAR_N_LOW = 8'h6E;
    localparam logic [7:0] CHAR_G_LOW = 8'h67;

    // command letters
    localparam logic [7:0] CMD_MODE   = 8'h4D;
    localparam logic [7:0] CMD_RUN    = 8'h42;
    localparam logic [7:0] CMD_DELAY  = 8'h54;
    localparam logic [7:0] CMD_PEDAL  = 8'h50;
    localparam logic [7:0] CMD_COUNT  = 8'h53;
    localparam logic [7:0] CMD_HALT   = 8'h44;

    // reply codes
    localparam logic [1:0] REPLY_PONG_OK   = 2'd0;
    localparam logic [1:0] REPLY_PONG_FAIL = 2'd1;
    localparam logic [1:0] REPLY_ACCEPT    = 2'd2;
    localparam logic [1:0] REPLY_REFUSE    = 2'd3;

    // argument limits
    localparam logic [7:0]  PING_KEY  = 8'd123;
    localparam logic [31:0] MODE_MAX  = 32'd2;
    localparam logic [31:0] DELAY_MAX = 32'd65535;
    localparam logic [35:0] ARG_MAX   = 36'h0_FFFF_FFFF;
    localparam logic [1:0]  MODE_BAD  = 2'd3;

    // summary of a finished line
    typedef struct packed {
        logic        nonempty;
        logic        semi_ok;
        logic        ping_ok;
        logic [7:0]  letter;
        logic [31:0] value;
    } line_info_t;

    function automatic logic is_terminator(input logic [7:0] b);
        return (b == CHAR_CR) || (b == CHAR_LF);
    endfunction

endpackage

// File: hw/rtl/slcd_line_parser.sv
// ----------------------------------------------------------------------------
// slcd_line_parser
// gathers a line byte by byte, tracks its prefix and folds the argument into
// a saturating decimal accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcd_line_parser
    import slcd_pkg::*;
#(
    parameter int LINE_BYTES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_take,
    input  logic [7:0] byte_data,
    output logic       line_end,
    output line_info_t info
);

    localparam int DEPTH = LINE_BYTES - 1;
    localparam int LW    = $clog2(LINE_BYTES);

    logic [LW-1:0] len_reg,      len_next;
    logic          live_reg,     live_next;
    logic          nonempty_reg, nonempty_next;
    logic          semi_reg,     semi_next;
    logic          ping_pre_reg, ping_pre_next;
    logic          ping_full_reg, ping_full_next;
    logic [7:0]    letter_reg,   letter_next;
    logic [31:0]   acc_reg,      acc_next;
    logic          bad_reg,      bad_next;

    logic          term;
    logic          keep;
    logic          is_digit;
    logic [3:0]    digit;
    logic [35:0]   acc_ext;
    logic [35:0]   acc_wide;
    logic [31:0]   acc_step;

    assign term     = is_terminator(byte_data);
    assign keep     = (len_reg < LW'(DEPTH));
    assign is_digit = (byte_data >= CHAR_ZERO) && (byte_data <= CHAR_NINE);
    assign digit    = 4'(byte_data - CHAR_ZERO);

    // acc * 10 + digit, saturated to 32 bits
    assign acc_ext  = {4'b0, acc_reg};
    assign acc_wide = (acc_ext << 3) + (acc_ext << 1) + {32'b0, digit};
    assign acc_step = (acc_wide > ARG_MAX) ? ARG_MAX[31:0] : acc_wide[31:0];

    // per-byte line tracking
    always_comb
    begin
        len_next       = len_reg;
        live_next      = live_reg;
        nonempty_next  = nonempty_reg;
        semi_next      = semi_reg;
        ping_pre_next  = ping_pre_reg;
        ping_full_next = ping_full_reg;
        letter_next    = letter_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;

        if (byte_take && term)
        begin
            len_next       = '0;
            live_next      = 1'b1;
            nonempty_next  = 1'b0;
            semi_next      = 1'b0;
            ping_pre_next  = 1'b0;
            ping_full_next = 1'b0;
            acc_next       = '0;
            bad_next       = 1'b0;
        end
        else if (byte_take && keep)
        begin
            len_next = len_reg + LW'(1);
            if (live_reg && (byte_data == CHAR_NUL))
            begin
                // a zero byte ends the line text here
                live_next = 1'b0;
            end
            else if (live_reg)
            begin
                if (len_reg == LW'(0))
                begin
                    letter_next   = byte_data;
                    nonempty_next = 1'b1;
                    ping_pre_next = (byte_data == CHAR_P_LOW);
                end
                else if (len_reg == LW'(1))
                begin
                    semi_next     = (byte_data == CHAR_SEMI);
                    ping_pre_next = ping_pre_reg && (byte_data == CHAR_I_LOW);
                end
                else if (len_reg == LW'(2) || (len_reg == LW'(5) && ping_full_reg))
                begin
                    // argument starts here
                    acc_next = {28'b0, digit};
                    bad_next = !is_digit;
                    if (len_reg == LW'(2))
                        ping_pre_next = ping_pre_reg && (byte_data == CHAR_N_LOW);
                end
                else
                begin
                    acc_next = acc_step;
                    bad_next = bad_reg || !is_digit;
                    if (len_reg == LW'(3))
                        ping_pre_next = ping_pre_reg && (byte_data == CHAR_G_LOW);
                    if (len_reg == LW'(4))
                        ping_full_next = ping_pre_reg && (byte_data == CHAR_SEMI);
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            live_reg      <= 1'b1;
            nonempty_reg  <= 1'b0;
            semi_reg      <= 1'b0;
            ping_pre_reg  <= 1'b0;
            ping_full_reg <= 1'b0;
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            live_reg      <= live_next;
            nonempty_reg  <= nonempty_next;
            semi_reg      <= semi_next;
            ping_pre_reg  <= ping_pre_next;
            ping_full_reg <= ping_full_next;
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
        end
    end

    // letter needs no reset: only read once nonempty is set
    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
    end

    // summary of the line ended by this transaction
    assign line_end      = byte_take && term && (len_reg != '0);
    assign info.nonempty = nonempty_reg;
    assign info.semi_ok  = semi_reg;
    assign info.ping_ok  = ping_full_reg;
    assign info.letter   = letter_reg;
    assign info.value    = bad_reg ? 32'd0 : acc_reg;

endmodule

// File: hw/rtl/slcd_cmd_exec.sv
// ----------------------------------------------------------------------------
// slcd_cmd_exec
// applies a finished line to the settings and holds the reply register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slcd_cmd_exec
    import slcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_end,
    input  line_info_t  info,
    input  logic        reply_stall,
    output logic        reply_valid,
    output logic [1:0]  reply_code,
    output logic [7:0]  command_letter,
    output logic        session_active,
    output logic [1:0]  op_mode,
    output logic        run_active,
    output logic        run_start,
    output logic        run_stop,
    output logic [15:0] delay_time,
    output logic        pedal_enable,
    output logic [31:0] pedal_count,
    output logic        emergency_halt
);

    // settings
    logic        session_reg, session_next;
    logic [1:0]  mode_reg,    mode_next;
    logic [2:0]  run_reg,     run_next;
    logic [15:0] delay_reg,   delay_next;
    logic        pedal_reg,   pedal_next;
    logic [31:0] count_reg,   count_next;
    logic        halt_reg,    halt_next;

    // reply register
    logic        valid_reg, valid_next;
    logic [1:0]  code_reg;
    logic [7:0]  letter_reg;
    logic [1:0]  code_next;
    logic [7:0]  letter_next;
    logic        do_reply;

    logic [31:0] v;

    assign v = info.value;

    // line decode
    always_comb
    begin
        session_next = session_reg;
        mode_next    = mode_reg;
        run_next     = run_reg;
        delay_next   = delay_reg;
        pedal_next   = pedal_reg;
        count_next   = count_reg;
        halt_next    = halt_reg;
        code_next    = REPLY_REFUSE;
        letter_next  = info.letter;
        do_reply     = 1'b0;

        if (info.nonempty && info.ping_ok)
        begin
            do_reply     = 1'b1;
            letter_next  = CHAR_P_LOW;
            session_next = (v[7:0] == PING_KEY);
            code_next    = (v[7:0] == PING_KEY) ? REPLY_PONG_OK : REPLY_PONG_FAIL;
        end
        else if (info.nonempty && info.semi_ok)
        begin
            do_reply = 1'b1;
            unique case (info.letter)
                CMD_MODE:
                begin
                    if (v <= MODE_MAX)
                    begin
                        mode_next = v[1:0];
                        code_next = REPLY_ACCEPT;
                    end
                end
                CMD_RUN:
                begin
                    if (v == 32'd1)
                    begin
                        run_next  = 3'b011;
                        code_next = REPLY_ACCEPT;
                    end
                    else if (v == 32'd0)
                    begin
                        run_next  = 3'b100;
                        code_next = REPLY_ACCEPT;
                    end
                end
                CMD_DELAY:
                begin
                    delay_next = (v > DELAY_MAX) ? DELAY_MAX[15:0] : v[15:0];
                    code_next  = REPLY_ACCEPT;
                end
                CMD_PEDAL:
                begin
                    if (v <= 32'd1)
                    begin
                        pedal_next = v[0];
                        code_next  = REPLY_ACCEPT;
                    end
                end
                CMD_COUNT:
                begin
                    count_next = v;
                    code_next  = REPLY_ACCEPT;
                end
                CMD_HALT:
                begin
                    if (v <= 32'd1)
                    begin
                        halt_next = v[0];
                        code_next = REPLY_ACCEPT;
                    end
                end
                default:
                begin
                    do_reply = 1'b0;
                end
            endcase
        end
    end

    // reply valid: set by a replying line, cleared once taken
    always_comb
    begin
        valid_next = valid_reg;
        if (line_end && do_reply)
            valid_next = 1'b1;
        else if (!reply_stall)
            valid_next = 1'b0;
    end

    // settings and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= 1'b0;
            mode_reg    <= '0;
            run_reg     <= '0;
            delay_reg   <= '0;
            pedal_reg   <= 1'b0;
            count_reg   <= '0;
            halt_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (line_end && do_reply)
            begin
                session_reg <= session_next;
                mode_reg    <= mode_next;
                run_reg     <= run_next;
                delay_reg   <= delay_next;
                pedal_reg   <= pedal_next;
                count_reg   <= count_next;
                halt_reg    <= halt_next;
            end
        end
    end

    // reply payload
    always_ff @(posedge clk)
    begin
        if (line_end && do_reply)
        begin
            code_reg   <= code_next;
            letter_reg <= letter_next;
        end
    end

    assign reply_valid    = valid_reg;
    assign reply_code     = code_reg;
    assign command_letter = letter_reg;
    assign session_active = session_reg;
    assign op_mode        = mode_reg;
    assign run_active     = run_reg[0];
    assign run_start      = run_reg[1];
    assign run_stop       = run_reg[2];
    assign delay_time     = delay_reg;
    assign pedal_enable   = pedal_reg;
    assign pedal_count    = count_reg;
    assign emergency_halt = halt_reg;

    // checks
    `ASSERT_IMPLY(a_no_overrun, line_end && valid_reg, !reply_stall, "line end over stalled reply")
    `ASSERT_IMPLY(a_pong_session, valid_reg && code_reg == REPLY_PONG_OK, session_reg, "pong ok without session")
    `ASSERT_ALWAYS(a_mode_range, mode_reg != MODE_BAD, "mode out of range")
    `ASSERT_ALWAYS(a_run_flags, !(run_reg[0] && run_reg[2]) && (run_reg[0] == run_reg[1]), "run flags inconsistent")

endmodule

// File: hw/rtl/serial_line_command_decoder.sv
// A reply appears in the cycle after the CR or LF transaction that ends its line.
// Throughput: one byte per cycle while rx_stall is low; the argument is folded into a decimal accumulator per byte.
// A terminator waits only while a previous reply is still stalled; other bytes keep flowing.
// Reset (rst_n low, asynchronous) empties the line and clears all settings and the reply valid flag.
// ----------------------------------------------------------------------------
// serial_line_command_decoder
// decodes ping and one-letter setting commands from a stream of received bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_line_command_decoder
    import slcd_pkg::*;
#(
    parameter int LINE_BYTES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        reply_valid,
    input  logic        reply_stall,
    output logic [1:0]  reply_code,
    output logic [7:0]  command_letter,
    output logic        session_active,
    output logic [1:0]  op_mode,
    output logic        run_active,
    output logic        run_start,
    output logic        run_stop,
    output logic [15:0] delay_time,
    output logic        pedal_enable,
    output logic [31:0] pedal_count,
    output logic        emergency_halt
);

    logic       byte_take;
    logic       line_end;
    line_info_t info;

    // hold a terminator while the previous reply is still waiting
    assign rx_stall  = reply_valid && reply_stall && is_terminator(rx_byte);
    assign byte_take = rx_valid && !rx_stall;

    slcd_line_parser #(
        .LINE_BYTES (LINE_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .byte_data (rx_byte),
        .line_end  (line_end),
        .info      (info)
    );

    slcd_cmd_exec u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .line_end       (line_end),
        .info           (info),
        .reply_stall    (reply_stall),
        .reply_valid    (reply_valid),
        .reply_code     (reply_code),
        .command_letter (command_letter),
        .session_active (session_active),
        .op_mode        (op_mode),
        .run_active     (run_active),
        .run_start      (run_start),
        .run_stop       (run_stop),
        .delay_time     (delay_time),
        .pedal_enable   (pedal_enable),
        .pedal_count    (pedal_count),
        .emergency_halt (emergency_halt)
    );

endmodule
